// ===== rtl/preamble_sync_bit_deframer_assert.svh =====
// Assertion macros used by the checker module of the bit deframer.
`ifndef PREAMBLE_SYNC_BIT_DEFRAMER_ASSERT_SVH
`define PREAMBLE_SYNC_BIT_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define PSBD_ASSERT_NOW(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("psbd assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define PSBD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("psbd assertion failed");

`endif

// ===== rtl/psbd_pkg.sv =====
// Package with the constants, types and helpers of the bit deframer.
`timescale 1ns / 1ps
`default_nettype none
package psbd_pkg;

	localparam int MAX_FRAME_BITS = 1024;
	localparam int FIDX_W = $clog2(MAX_FRAME_BITS);
	localparam int INDEX_W = 10;
	localparam int FLIPS_W = 4;
	localparam int ZRUN_W = 4;
	localparam int CAUSE_W = 2;

	localparam logic [ZRUN_W-1:0] ZERO_RUN_END = ZRUN_W'(8);
	localparam logic [2:0] INDEX_ALIGN_MASK = 3'h7;
	localparam logic [FLIPS_W-1:0] RESET_FLIPS = FLIPS_W'(4);
	localparam logic [FIDX_W-1:0] LAST_FRAME_IDX = FIDX_W'(MAX_FRAME_BITS - 1);

	localparam logic [CAUSE_W-1:0] CAUSE_NONE = 2'd0;
	localparam logic [CAUSE_W-1:0] CAUSE_ZERO_RUN = 2'd1;
	localparam logic [CAUSE_W-1:0] CAUSE_BUF_FULL = 2'd2;

	typedef struct packed {
		logic                emit;
		logic                data_bit;
		logic [INDEX_W-1:0]  bit_index;
		logic                last;
		logic [CAUSE_W-1:0]  end_cause;
	} psbd_result_t;

	// Reports the low INDEX_W bits of the frame position on the output port; they hold the whole position.
	function automatic logic [INDEX_W-1:0] to_bit_index(input logic [FIDX_W-1:0] idx);
		logic [31:0] wide;
		wide = 32'(idx);
		return wide[INDEX_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/psbd_core.sv =====
// Hunting and framing state of the deframer, updated once per bit.
`timescale 1ns / 1ps
`default_nettype none
module psbd_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic                          bit_in,
	input  wire logic [psbd_pkg::FLIPS_W-1:0]  preamble_flips,
	output psbd_pkg::psbd_result_t             res
);
	import psbd_pkg::*;

	logic                receiving_q, receiving_d;
	logic [FLIPS_W-1:0]  flip_count_q, flip_count_d;
	logic                prev_bit_q, prev_bit_d;
	logic [FIDX_W-1:0]   frame_idx_q, frame_idx_d;
	logic [ZRUN_W-1:0]   zero_run_q, zero_run_d;
	logic [ZRUN_W-1:0]   zrun_upd;
	logic [CAUSE_W-1:0]  cause;

	always_comb begin
		receiving_d = receiving_q;
		flip_count_d = flip_count_q;
		prev_bit_d = prev_bit_q;
		frame_idx_d = frame_idx_q;
		zero_run_d = zero_run_q;
		res = '0;
		cause = CAUSE_NONE;
		if (bit_in) begin
			zrun_upd = '0;
		end else if (zero_run_q < ZERO_RUN_END) begin
			zrun_upd = zero_run_q + ZRUN_W'(1);
		end else begin
			zrun_upd = zero_run_q;
		end
		if (step) begin
			if (!receiving_q) begin
				if (flip_count_q == '0 && bit_in && prev_bit_q) begin
					// Start pair of ones: the start bit itself is dropped.
					receiving_d = 1'b1;
					frame_idx_d = '0;
					zero_run_d = '0;
				end else if (flip_count_q != '0 && bit_in != prev_bit_q) begin
					flip_count_d = flip_count_q - FLIPS_W'(1);
				end else if (bit_in == prev_bit_q) begin
					flip_count_d = preamble_flips;
				end
				prev_bit_d = bit_in;
			end else begin
				if (zrun_upd >= ZERO_RUN_END &&
				    (frame_idx_q[2:0] & INDEX_ALIGN_MASK) == 3'd0) begin
					cause = CAUSE_ZERO_RUN;
				end else if (frame_idx_q == LAST_FRAME_IDX) begin
					cause = CAUSE_BUF_FULL;
				end
				res.emit = 1'b1;
				res.data_bit = bit_in;
				res.bit_index = to_bit_index(frame_idx_q);
				res.last = (cause != CAUSE_NONE);
				res.end_cause = cause;
				if (cause != CAUSE_NONE) begin
					receiving_d = 1'b0;
					frame_idx_d = '0;
					zero_run_d = '0;
				end else begin
					frame_idx_d = frame_idx_q + FIDX_W'(1);
					zero_run_d = zrun_upd;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			flip_count_q <= RESET_FLIPS;
			prev_bit_q <= 1'b1;
			frame_idx_q <= '0;
			zero_run_q <= '0;
		end else begin
			receiving_q <= receiving_d;
			flip_count_q <= flip_count_d;
			prev_bit_q <= prev_bit_d;
			frame_idx_q <= frame_idx_d;
			zero_run_q <= zero_run_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/preamble_sync_bit_deframer.sv =====
// Top level of the preamble synchronized bit deframer.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one decided channel bit per input item and hunts for a
// preamble of alternating bits followed by a pair of ones; after that pair it
// emits every received bit as a result item with its position in the frame,
// flags the bit that closes the frame with last, and tells in end_cause
// whether a run of eight or more zeros ending on a byte boundary or the end
// of the frame buffer closed it. Bits taken while hunting, and the start bit,
// give no result. One item is accepted in every cycle while in_ready is high;
// the bit waits in the input register while the state update computes its
// result, and the result register then loads that result. The state update
// loop in the core sets that rate. A result that waits on out_ready holds a
// full input register, and then in_ready falls: the input register keeps
// taking bits as long as it is empty or the result register is free or is
// being emptied in the same cycle. The preamble_flips register is written
// through the cfg channel, which is always ready; a write takes effect at the
// next reload of the flip counter, not on a counter already loaded.
module preamble_sync_bit_deframer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_ready,
	input  wire logic                            channel_bit,
	output      logic                            out_valid,
	input  wire logic                            out_ready,
	output      logic                            data_bit,
	output      logic [psbd_pkg::INDEX_W-1:0]    bit_index,
	output      logic                            last,
	output      logic [psbd_pkg::CAUSE_W-1:0]    end_cause,
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic [psbd_pkg::FLIPS_W-1:0]    cfg_data
);
	import psbd_pkg::*;

	logic [FLIPS_W-1:0]  flips_q;
	logic                valid_s1;
	logic                bit_s1;
	logic                out_free;
	logic                step;
	psbd_result_t        res;
	logic                out_valid_q;
	psbd_result_t        out_q;

	// The configuration register is a plain write: nothing ever holds it off.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flips_q <= RESET_FLIPS;
		end else if (cfg_valid && cfg_ready) begin
			flips_q <= cfg_data;
		end
	end

	// The result register is free when empty or being taken this cycle.
	assign out_free = !out_valid_q || out_ready;
	assign step = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			bit_s1 <= channel_bit;
		end
	end

	psbd_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.bit_in         (bit_s1),
		.preamble_flips (flips_q),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign data_bit = out_q.data_bit;
	assign bit_index = out_q.bit_index;
	assign last = out_q.last;
	assign end_cause = out_q.end_cause;

endmodule
`default_nettype wire

// ===== rtl/psbd_checker.sv =====
// Port-level checker of the bit deframer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "preamble_sync_bit_deframer_assert.svh"
module psbd_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic                            data_bit,
	input wire logic [psbd_pkg::INDEX_W-1:0]    bit_index,
	input wire logic                            last,
	input wire logic [psbd_pkg::CAUSE_W-1:0]    end_cause
);
	import psbd_pkg::*;

	// A closing bit always names its cause, and an open one names none.
	`PSBD_ASSERT_NOW(a_last_has_cause, clk, arst_n, out_valid && last, end_cause != CAUSE_NONE)
	`PSBD_ASSERT_NOW(a_open_no_cause, clk, arst_n, out_valid && !last, end_cause == CAUSE_NONE)

	// A zero-run end falls on a zero bit at a byte-aligned position.
	`PSBD_ASSERT_NOW(a_zero_run_aligned, clk, arst_n, out_valid && end_cause == CAUSE_ZERO_RUN,
		!data_bit && bit_index[2:0] == 3'd0)

	// A result that is not taken stays on the port unchanged.
	`PSBD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(data_bit) && $stable(bit_index) && $stable(last) &&
		$stable(end_cause))

endmodule

bind preamble_sync_bit_deframer psbd_checker u_psbd_checker (.*);
`default_nettype wire
